/* rtl/twk_pkg.sv */
package twk_pkg;

	localparam int GLYPH_COUNT    = 256;
	localparam int WIDTH_BITS_DEF = 24;
	localparam int PAIR_SHIFT     = 8;
	localparam int KERN_DEPTH     = GLYPH_COUNT << PAIR_SHIFT;

	localparam logic [7:0] ESCAPE_BYTE  = 8'hA7;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] MONO_ADVANCE = 8'd1;

	typedef enum logic [2:0] {
		FUNC_MEASURE    = 3'd0,
		FUNC_WR_ADV     = 3'd1,
		FUNC_WR_KERN    = 3'd2,
		FUNC_CLEAR_LOAD = 3'd3,
		FUNC_MONO       = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_KERN,
		ST_DRAW,
		ST_DONE,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic latch_item;
		logic wr_adv;
		logic wr_kern;
		logic start_clear;
		logic fill_one;
		logic clearing;
		logic do_kern;
		logic do_draw;
		logic do_emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_busy;
		logic last;
	} stat_t;

endpackage

/* rtl/twk_ram.sv */
module twk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/twk_ctrl.sv */
module twk_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  twk_pkg::func_t func,
	input  twk_pkg::stat_t stat,
	output logic           s_tready,
	output twk_pkg::cmd_t  cmd
);

	import twk_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = s_tvalid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (func) inside
						FUNC_MEASURE:               state_d = ST_READ;
						FUNC_CLEAR_LOAD, FUNC_MONO: state_d = ST_CLEAR;
						default:                    state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ:  state_d = ST_KERN;
			ST_KERN:  state_d = ST_DRAW;
			ST_DRAW:  state_d = stat.last ? ST_DONE : ST_IDLE;
			ST_DONE:  state_d = stat.out_busy ? ST_DONE : ST_IDLE;
			ST_CLEAR: state_d = stat.clear_done ? ST_IDLE : ST_CLEAR;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready        = (state_q == ST_IDLE);
		cmd             = '0;
		cmd.latch_item  = accept && (func == FUNC_MEASURE);
		cmd.wr_adv      = accept && (func == FUNC_WR_ADV);
		cmd.wr_kern     = accept && (func == FUNC_WR_KERN);
		cmd.start_clear = accept && ((func == FUNC_CLEAR_LOAD) || (func == FUNC_MONO));
		cmd.fill_one    = (func == FUNC_MONO);
		cmd.clearing    = (state_q == ST_CLEAR);
		cmd.do_kern     = (state_q == ST_KERN);
		cmd.do_draw     = (state_q == ST_DRAW);
		cmd.do_emit     = (state_q == ST_DONE) && !stat.out_busy;
	end

endmodule

/* rtl/twk_datapath.sv */
module twk_datapath #(
	parameter int WIDTH_BITS = twk_pkg::WIDTH_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  twk_pkg::cmd_t                       cmd,
	output twk_pkg::stat_t                      stat,
	input  logic [7:0]                          text_byte,
	input  logic [7:0]                          pair_second,
	input  logic [7:0]                          advance_value,
	input  logic signed [7:0]                   kern_amount,
	input  logic                                last_byte,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [((WIDTH_BITS+7)/8)*8-1:0]     m_tdata
);

	import twk_pkg::*;

	localparam int AW = $clog2(GLYPH_COUNT);
	localparam int KW = $clog2(KERN_DEPTH);

	logic [7:0]                   byte_q;
	logic                         last_q;
	logic signed [WIDTH_BITS-1:0] line_q;
	logic signed [WIDTH_BITS-1:0] widest_q;
	logic [7:0]                   pend_glyph_q;
	logic                         pend_valid_q;
	logic                         skip_q;
	logic signed [WIDTH_BITS-1:0] out_q;
	logic                         out_valid_q;
	logic [7:0]                   fill_q;
	logic [KW-1:0]                cnt_q;

	logic          adv_we;
	logic [AW-1:0] adv_waddr;
	logic [7:0]    adv_wdata;
	logic [7:0]    adv_rd;
	logic          kern_we;
	logic [KW-1:0] kern_waddr;
	logic [7:0]    kern_wdata;
	logic [7:0]    kern_rd;

	function automatic logic signed [WIDTH_BITS-1:0] sat_add(
		input logic signed [WIDTH_BITS-1:0] a,
		input logic signed [8:0]            b
	);
		logic signed [WIDTH_BITS:0] sum;
		sum = {a[WIDTH_BITS-1], a} + {{(WIDTH_BITS-8){b[8]}}, b};
		if (sum[WIDTH_BITS] != sum[WIDTH_BITS-1]) begin
			sat_add = sum[WIDTH_BITS] ? {1'b1, {(WIDTH_BITS-1){1'b0}}}
			                          : {1'b0, {(WIDTH_BITS-1){1'b1}}};
		end else begin
			sat_add = sum[WIDTH_BITS-1:0];
		end
	endfunction

	// The clear sweep owns both write ports; the advance table only sees
	// the first GLYPH_COUNT addresses of the sweep.
	always_comb begin
		adv_we     = cmd.wr_adv || (cmd.clearing && (cnt_q[KW-1:AW] == '0));
		adv_waddr  = cmd.clearing ? cnt_q[AW-1:0] : text_byte;
		adv_wdata  = cmd.clearing ? fill_q : advance_value;
		kern_we    = cmd.wr_kern || cmd.clearing;
		kern_waddr = cmd.clearing ? cnt_q : {text_byte, pair_second};
		kern_wdata = cmd.clearing ? 8'd0 : kern_amount;
	end

	twk_ram #(
		.WIDTH (8),
		.DEPTH (GLYPH_COUNT)
	) u_adv_ram (
		.clk   (clk),
		.we    (adv_we),
		.waddr (adv_waddr),
		.wdata (adv_wdata),
		.raddr (byte_q),
		.rdata (adv_rd)
	);

	twk_ram #(
		.WIDTH (8),
		.DEPTH (KERN_DEPTH)
	) u_kern_ram (
		.clk   (clk),
		.we    (kern_we),
		.waddr (kern_waddr),
		.wdata (kern_wdata),
		.raddr ({pend_glyph_q, byte_q}),
		.rdata (kern_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			byte_q <= text_byte;
		end
		if (cmd.do_emit) begin
			out_q <= (line_q > widest_q) ? line_q : widest_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= 1'b0;
			line_q       <= '0;
			widest_q     <= '0;
			pend_glyph_q <= '0;
			pend_valid_q <= 1'b0;
			skip_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			fill_q       <= MONO_ADVANCE;
			cnt_q        <= '0;
		end else begin
			if (cmd.latch_item) begin
				last_q <= last_byte;
			end

			if (cmd.start_clear) begin
				fill_q <= cmd.fill_one ? MONO_ADVANCE : 8'd0;
				cnt_q  <= '0;
			end else if (cmd.clearing) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (cmd.do_kern) begin
				if (pend_valid_q) begin
					line_q       <= sat_add(line_q, {kern_rd[7], kern_rd});
					pend_valid_q <= 1'b0;
				end
			end else if (cmd.do_draw) begin
				if (skip_q) begin
					skip_q <= 1'b0;
				end else if (byte_q == ESCAPE_BYTE) begin
					skip_q <= 1'b1;
				end else if (byte_q == NEWLINE_BYTE) begin
					if (line_q > widest_q) begin
						widest_q <= line_q;
					end
					line_q <= '0;
				end else begin
					line_q       <= sat_add(line_q, {1'b0, adv_rd});
					pend_glyph_q <= byte_q;
					pend_valid_q <= 1'b1;
				end
			end else if (cmd.do_emit) begin
				line_q       <= '0;
				widest_q     <= '0;
				pend_glyph_q <= '0;
				pend_valid_q <= 1'b0;
				skip_q       <= 1'b0;
			end

			if (cmd.do_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.clear_done = cmd.clearing && (cnt_q == KW'(KERN_DEPTH - 1));
		stat.out_busy   = out_valid_q && !m_tready;
		stat.last       = last_q;
	end

	always_comb begin
		m_tdata                 = '0;
		m_tdata[WIDTH_BITS-1:0] = out_q;
	end

	assign m_tvalid = out_valid_q;

endmodule

/* rtl/text_width_with_kerning_core.sv */
// Text width meter for a bitmap font with pair kerning.
//
// Items enter on the s_ stream: tuser carries the function code, tdata the
// byte, the pair partner, the advance and the kerning amount, and tlast marks
// the final byte of a string. The widest line of a finished string leaves on
// the m_ stream as one signed, saturated width.
//
// A measure byte passes through one table read, one kerning add and one glyph
// step, all in sequence on the shared line register, before the next item can
// be taken. A final byte then moves the result into the output register once
// that register is free, and the result is then offered on m_tvalid.
// Advance and kerning writes leave the block idle and ready for the next item.
// Clearing for a load and restoring monospaced advances each sweep the
// 65536-entry kerning memory one entry per cycle, and no item is accepted
// until the sweep ends. The same sweep runs right after reset, leaving every
// advance at one pixel and every kerning at zero.
// While the receiver stalls, the result stays in the output register and input
// items keep flowing; only a second final byte waits for the register to empty.
module text_width_with_kerning_core #(
	parameter int WIDTH_BITS = twk_pkg::WIDTH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// text_byte[7:0], pair_second[15:8], advance_value[23:16], kern_amount[31:24]
	input  logic [31:0]                     s_tdata,
	// func[2:0]
	input  logic [2:0]                      s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// text_width[WIDTH_BITS-1:0], zero padded to whole bytes
	output logic [((WIDTH_BITS+7)/8)*8-1:0] m_tdata
);

	import twk_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	func_t func;

	assign func = func_t'(s_tuser);

	twk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (func),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	twk_datapath #(
		.WIDTH_BITS (WIDTH_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.text_byte     (s_tdata[7:0]),
		.pair_second   (s_tdata[15:8]),
		.advance_value (s_tdata[23:16]),
		.kern_amount   (s_tdata[31:24]),
		.last_byte     (s_tlast),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata)
	);

	// Only one source may drive the table write ports in a cycle.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_adv, cmd.wr_kern, cmd.clearing, cmd.latch_item}))
		else $error("table write port conflict");

	// A measure byte keeps the block busy for the cycle after acceptance.
	a_busy_after_measure: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_item |=> !s_tready)
		else $error("new item taken while a measure byte is in flight");

	// An emitted result is offered on the output in the following cycle.
	a_emit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_emit |=> m_tvalid)
		else $error("emitted width not presented");

endmodule
